>>> hdl/swrmj_pkg.sv
// Shared constants, types and slot helpers for the sliding window RTT mean and jitter block.
// Used by every module under hdl except swrmj_ram; depends on nothing else.
package swrmj_pkg;

  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 24;
  localparam int FILL_W   = 4;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int DIV_W    = SUM_W + (SUM_W % 2);
  localparam int DIV_ITER = DIV_W / 2;
  localparam int ITER_W   = $clog2(DIV_ITER);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD1  = 7'b0000010,
    ST_RD2  = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_DIVM = 7'b0010000,
    ST_DIVJ = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_prev;
    logic cap_prev;
    logic update;
    logic div_start;
    logic div_jit;
    logic cap_mean;
    logic cap_jit;
    logic clr_jit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic multi;
    logic div_done;
  } status_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(WINDOW - 1) : s - SLOT_W'(1);
  endfunction

endpackage

>>> hdl/swrmj_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swrmj_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/swrmj_div.sv
// Iterative unsigned divider, two quotient bits per cycle, shared by mean and jitter.
// Depends on swrmj_pkg for the sum and count widths.
module swrmj_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swrmj_pkg::SUM_W-1:0] dividend_i,
  input  logic [swrmj_pkg::CNT_W-1:0] divisor_i,
  output logic [swrmj_pkg::DIV_W-1:0] quot_o,
  output logic                       done_o
);
  import swrmj_pkg::*;

  logic [DIV_W-1:0]  q_q, q_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q, done_q;

  always_comb begin
    logic [CNT_W:0]   rw;
    logic [DIV_W-1:0] q;
    logic [CNT_W-1:0] r;
    q = q_q;
    r = r_q;
    for (int i = 0; i < 2; i++) begin
      rw = {r, q[DIV_W-1]};
      if (rw >= {1'b0, dvs_q}) begin
        r = CNT_W'(rw - {1'b0, dvs_q});
        q = {q[DIV_W-2:0], 1'b1};
      end else begin
        r = rw[CNT_W-1:0];
        q = {q[DIV_W-2:0], 1'b0};
      end
    end
    q_d = q;
    r_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ITER_W'(1);
        if (cnt_q == ITER_W'(DIV_ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= DIV_W'(dividend_i);
      r_q   <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

>>> hdl/swrmj_datapath.sv
// Datapath: sample and difference rings, running sums, divider and result registers.
// Depends on swrmj_pkg, swrmj_ram and swrmj_div.
module swrmj_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swrmj_pkg::cmd_t               cmd_i,
  output swrmj_pkg::status_t            status_o,
  input  logic [swrmj_pkg::SAMPLE_W-1:0] rtt_us_i,
  output logic [swrmj_pkg::FILL_W-1:0]   fill_count_o,
  output logic [swrmj_pkg::SAMPLE_W-1:0] mean_rtt_us_o,
  output logic [swrmj_pkg::SAMPLE_W-1:0] jitter_us_o
);
  import swrmj_pkg::*;

  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [SUM_W-1:0]    ssum_q, ssum_d, dsum_q, dsum_d;
  logic [SAMPLE_W-1:0] x_q, prev_q, olddiff_q, d;
  logic [SAMPLE_W-1:0] mean_q, jit_q;
  logic [FILL_W-1:0]   fill_out_q;
  logic [SAMPLE_W-1:0] mean_out_q, jit_out_q;
  logic [SAMPLE_W-1:0] s_rdata, d_rdata, d_wdata;
  logic [SLOT_W-1:0]   s_raddr;
  logic                empty, full;
  logic [SUM_W-1:0]    div_dividend;
  logic [CNT_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quot;
  logic                div_done;

  assign empty = (held_q == '0);
  assign full  = (held_q == CNT_W'(WINDOW));
  assign d     = (x_q >= prev_q) ? x_q - prev_q : prev_q - x_q;

  always_comb begin
    if (empty) begin
      ssum_d  = SUM_W'(x_q);
      dsum_d  = '0;
      held_d  = CNT_W'(1);
      d_wdata = '0;
    end else begin
      ssum_d  = ssum_q - (full ? SUM_W'(s_rdata) : '0) + SUM_W'(x_q);
      dsum_d  = dsum_q - (full ? SUM_W'(olddiff_q) : '0) + SUM_W'(d);
      held_d  = full ? held_q : held_q + CNT_W'(1);
      d_wdata = d;
    end
  end

  assign s_raddr = cmd_i.rd_prev ? slot_prev(slot_q) : slot_q;

  swrmj_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (x_q),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  swrmj_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (d_wdata),
    .raddr_i (slot_next(slot_q)),
    .rdata_o (d_rdata)
  );

  assign div_dividend = cmd_i.div_jit ? dsum_q : ssum_d;
  assign div_divisor  = cmd_i.div_jit ? held_q - CNT_W'(1) : held_d;

  swrmj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      held_q <= '0;
      ssum_q <= '0;
      dsum_q <= '0;
    end else if (cmd_i.update) begin
      slot_q <= slot_next(slot_q);
      held_q <= held_d;
      ssum_q <= ssum_d;
      dsum_q <= dsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= rtt_us_i;
    end
    if (cmd_i.cap_prev) begin
      prev_q    <= s_rdata;
      olddiff_q <= d_rdata;
    end
    if (cmd_i.cap_mean) begin
      mean_q <= SAMPLE_W'(div_quot);
    end
    if (cmd_i.cap_jit) begin
      jit_q <= SAMPLE_W'(div_quot);
    end else if (cmd_i.clr_jit) begin
      jit_q <= '0;
    end
    if (cmd_i.out_load) begin
      fill_out_q <= FILL_W'(held_q);
      mean_out_q <= mean_q;
      jit_out_q  <= jit_q;
    end
  end

  assign status_o.empty    = empty;
  assign status_o.multi    = (held_q >= CNT_W'(2));
  assign status_o.div_done = div_done;

  assign fill_count_o  = fill_out_q;
  assign mean_rtt_us_o = mean_out_q;
  assign jitter_us_o   = jit_out_q;

endmodule

>>> hdl/swrmj_ctrl.sv
// Controller state machine: sequences ring reads, sum update, one or two divisions, output.
// Depends on swrmj_pkg for the state encoding and the command and status structs.
module swrmj_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output swrmj_pkg::cmd_t    cmd_o,
  input  swrmj_pkg::status_t status_i
);
  import swrmj_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = status_i.empty ? ST_UPD : ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd_prev = 1'b1;
        state_d     = ST_RD2;
      end
      ST_RD2: begin
        cmd.cap_prev = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd.update    = 1'b1;
        cmd.div_start = 1'b1;
        state_d       = ST_DIVM;
      end
      ST_DIVM: begin
        if (status_i.div_done) begin
          cmd.cap_mean = 1'b1;
          if (status_i.multi) begin
            cmd.div_start = 1'b1;
            cmd.div_jit   = 1'b1;
            state_d       = ST_DIVJ;
          end else begin
            cmd.clr_jit = 1'b1;
            state_d     = ST_OUT;
          end
        end
      end
      ST_DIVJ: begin
        if (status_i.div_done) begin
          cmd.cap_jit = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("controller stayed ready after taking an item");

  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIVM || state_q == ST_DIVJ))
    else $error("divider finished outside a division state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while holding an untaken result");

  a_result_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> (out_valid_o && in_ready_o))
    else $error("output load did not raise valid and return to idle");

endmodule

>>> hdl/sliding_window_rtt_mean_jitter.sv
// Top level of the sliding window RTT mean and jitter block.
// Depends on swrmj_pkg, swrmj_ctrl and swrmj_datapath.
//
// Input channel: in_valid_i / in_ready_o carry one RTT sample (rtt_us_i, microseconds).
// Output channel: out_valid_o / out_ready_i carry one result item per sample:
// the window fill count, the truncated window mean and the truncated mean absolute
// difference between adjacent samples (zero while fewer than two samples are held).
// Each sample is processed alone. After acceptance the rings are read for the previous
// sample, the oldest sample and the oldest difference, the sums are updated, and one
// shared divider produces two quotient bits per cycle, first for the mean and then for
// the jitter; the output register is loaded last. The first sample after reset needs no
// ring reads and no jitter division. in_ready_o rises in the same cycle as the result
// becomes valid. Reset clears the fill count, the write slot and the sums; the rings
// need no clearing, since data from a slot is used only after the slot has been
// written. If the receiver stalls, the finished result waits in the output register
// while the next sample is accepted and processed; only the final output load waits
// until the held result is taken.
module sliding_window_rtt_mean_jitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [swrmj_pkg::SAMPLE_W-1:0] rtt_us_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [swrmj_pkg::FILL_W-1:0]   fill_count_o,
  output logic [swrmj_pkg::SAMPLE_W-1:0] mean_rtt_us_o,
  output logic [swrmj_pkg::SAMPLE_W-1:0] jitter_us_o
);
  import swrmj_pkg::*;

  cmd_t    cmd;
  status_t status;

  swrmj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  swrmj_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .rtt_us_i      (rtt_us_i),
    .fill_count_o  (fill_count_o),
    .mean_rtt_us_o (mean_rtt_us_o),
    .jitter_us_o   (jitter_us_o)
  );

endmodule
